@@ hw/rtl/sdoc_pkg.sv @@
// Shared types and constants of the expedited SDO client.
// No dependencies; imported by the top level and by the front and back parts.
`timescale 1ns / 1ps

package sdoc_pkg;

	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [10:0] TX_BASE    = 11'h600;
	localparam logic [10:0] RX_BASE    = 11'h580;
	localparam logic [7:0]  CCS_UPLOAD = 8'h40;
	localparam logic [7:0]  CLASS_MASK = 8'hE0;
	localparam logic [7:0]  EXP_BIT    = 8'h02;
	localparam logic [7:0]  SIZE_BIT   = 8'h01;
	localparam logic [7:0]  DL_CMD     = 8'h23;
	localparam logic [7:0]  DL_ACK     = 8'h60;
	localparam logic [23:0] TIMEOUT_RST = 24'd100000;
	localparam logic [23:0] TICKS_MAX   = 24'hFFFFFF;

	localparam logic REG_BUS_ON  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		CMD_UPLOAD   = 2'd0,
		CMD_DOWNLOAD = 2'd1,
		CMD_FRAME    = 2'd2,
		CMD_TICK     = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BUS     = 3'd1,
		ST_SIZE    = 3'd2,
		ST_BADRESP = 3'd3,
		ST_NOTEXP  = 3'd4,
		ST_TIMEOUT = 3'd5,
		ST_BUSY    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_UPLOAD   = 2'd1,
		PH_DOWNLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		cmd_t        cmd;
		logic        size_ok;
		logic [10:0] tx_id;
		logic [10:0] exp_id;
		logic [63:0] frame;
		logic        rx_hi_zero;
		logic [10:0] rx_lo;
		logic        dl_ack;
		logic        up_class_ok;
		logic        up_exp;
		logic [31:0] up_value;
		logic [2:0]  up_size;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [10:0] tx_id;
		logic [63:0] tx_data;
		logic        done_res;
		status_t     status;
		logic [31:0] read_value;
		logic [2:0]  read_size;
	} result_t;

endpackage

@@ hw/rtl/canopen_sdo_expedited_client.sv @@
// Top level of the expedited SDO client: front classifier, back executor.
// Depends on sdoc_pkg, sdoc_front and sdoc_back.
`timescale 1ns / 1ps

// Words (start upload, start download, received frame, tick) enter through a
// queue-style push/full port and land in a QUEUE_DEPTH-entry queue after being
// classified and packed. The back part takes one word per cycle while its result
// queue is not full, updates the transfer state in that cycle and writes any
// result into its own QUEUE_DEPTH-entry result queue, read through empty/pop.
// Sustained rate is one word per clock while the result queue has room; a
// word's result, once taken from the front queue, is popped from the result
// queue. Registers bus_on (index 0) and timeout_ticks (index 1) are written
// through wr_en, wr_index and wr_data, and are to be changed only while the
// block is idle.

module canopen_sdo_expedited_client import sdoc_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [6:0]  server_node,
	input  logic [15:0] object_index,
	input  logic [7:0]  object_subindex,
	input  logic [31:0] write_value,
	input  logic [3:0]  write_size,
	input  logic [28:0] rx_id,
	input  logic [63:0] rx_data,
	output logic        empty,
	input  logic        pop,
	output logic        tx_valid,
	output logic [10:0] tx_id,
	output logic [63:0] tx_data,
	output logic        done_res,
	output logic [2:0]  status,
	output logic [31:0] read_value,
	output logic [2:0]  read_size,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [23:0] wr_data
);

	item_t   item;
	logic    item_valid;
	logic    item_take;
	result_t res_head;

	sdoc_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.command        (command),
		.server_node    (server_node),
		.object_index   (object_index),
		.object_subindex(object_subindex),
		.write_value    (write_value),
		.write_size     (write_size),
		.rx_id          (rx_id),
		.rx_data        (rx_data),
		.item_valid     (item_valid),
		.item           (item),
		.item_take      (item_take)
	);

	sdoc_back #(
		.DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item      (item),
		.item_take (item_take),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.res_head  (res_head),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign tx_valid   = res_head.tx_valid;
	assign tx_id      = res_head.tx_id;
	assign tx_data    = res_head.tx_data;
	assign done_res   = res_head.done_res;
	assign status     = res_head.status;
	assign read_value = res_head.read_value;
	assign read_size  = res_head.read_size;

endmodule

@@ hw/rtl/sdoc_fifo.sv @@
// Small first-in first-out queue of fixed-width words.
// No dependencies; used by the front and back parts.
`timescale 1ns / 1ps

module sdoc_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ hw/rtl/sdoc_front.sv @@
// Front part: classifies each accepted word and packs request frames.
// Depends on sdoc_pkg and sdoc_fifo.
`timescale 1ns / 1ps

module sdoc_front import sdoc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  command,
	input  logic [6:0]  server_node,
	input  logic [15:0] object_index,
	input  logic [7:0]  object_subindex,
	input  logic [31:0] write_value,
	input  logic [3:0]  write_size,
	input  logic [28:0] rx_id,
	input  logic [63:0] rx_data,
	output logic        item_valid,
	output item_t       item,
	input  logic        item_take
);

	item_t       cls;
	logic [31:0] wr_mask;
	logic [1:0]  unused;
	logic [7:0]  c0;
	logic [2:0]  up_size;
	logic [31:0] up_mask;
	logic        item_empty;

	always_comb begin
		cls     = '0;
		c0      = rx_data[7:0];
		wr_mask = '0;
		up_mask = '0;
		unused  = 2'(3'd4 - write_size[2:0]);
		case (write_size[2:0])
			3'd1:    wr_mask = 32'h0000_00FF;
			3'd2:    wr_mask = 32'h0000_FFFF;
			3'd3:    wr_mask = 32'h00FF_FFFF;
			default: wr_mask = 32'hFFFF_FFFF;
		endcase
		up_size = ((c0 & SIZE_BIT) != '0) ? 3'd4 - {1'b0, c0[3:2]} : 3'd4;
		case (up_size)
			3'd1:    up_mask = 32'h0000_00FF;
			3'd2:    up_mask = 32'h0000_FFFF;
			3'd3:    up_mask = 32'h00FF_FFFF;
			default: up_mask = 32'hFFFF_FFFF;
		endcase
		cls.cmd     = cmd_t'(command);
		cls.size_ok = (write_size != 4'd0) && (write_size <= 4'd4);
		cls.tx_id   = TX_BASE + {4'b0, server_node};
		cls.exp_id  = RX_BASE + {4'b0, server_node};
		if (cmd_t'(command) == CMD_DOWNLOAD) begin
			cls.frame = {write_value & wr_mask, object_subindex, object_index,
				DL_CMD | {4'b0, unused, 2'b00}};
		end else begin
			cls.frame = {32'b0, object_subindex, object_index, CCS_UPLOAD};
		end
		cls.rx_hi_zero  = (rx_id[28:11] == '0);
		cls.rx_lo       = rx_id[10:0];
		cls.dl_ack      = (c0 == DL_ACK);
		cls.up_class_ok = ((c0 & CLASS_MASK) == CCS_UPLOAD);
		cls.up_exp      = ((c0 & EXP_BIT) != '0);
		cls.up_value    = rx_data[63:32] & up_mask;
		cls.up_size     = up_size;
	end

	sdoc_fifo #(
		.WIDTH($bits(item_t)),
		.DEPTH(DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cls),
		.full  (full),
		.pop   (item_take),
		.dout  (item),
		.empty (item_empty)
	);

	assign item_valid = !item_empty;

endmodule

@@ hw/rtl/sdoc_back.sv @@
// Back part: transfer state, timeout count and result queue.
// Depends on sdoc_pkg and sdoc_fifo.
`timescale 1ns / 1ps

module sdoc_back import sdoc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  item_t       item,
	output logic        item_take,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [23:0] wr_data,
	output result_t     res_head,
	output logic        res_empty,
	input  logic        res_pop
);

	phase_t      phase_q;
	phase_t      phase_d;
	logic [10:0] exp_id_q;
	logic [10:0] exp_id_d;
	logic [23:0] elapsed_q;
	logic [23:0] elapsed_d;
	logic [23:0] elapsed_inc;
	logic        bus_on_q;
	logic [23:0] timeout_q;
	logic        waiting;
	logic        res_full;
	logic        res_push;
	result_t     res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_on_q  <= 1'b0;
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_BUS_ON:  bus_on_q  <= wr_data[0];
				REG_TIMEOUT: timeout_q <= wr_data;
				default:     timeout_q <= timeout_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			exp_id_q  <= '0;
			elapsed_q <= '0;
		end else begin
			phase_q   <= phase_d;
			exp_id_q  <= exp_id_d;
			elapsed_q <= elapsed_d;
		end
	end

	assign waiting     = (phase_q == PH_UPLOAD) || (phase_q == PH_DOWNLOAD);
	assign elapsed_inc = elapsed_q + {23'b0, (elapsed_q != TICKS_MAX)};

	always_comb begin
		phase_d   = phase_q;
		exp_id_d  = exp_id_q;
		elapsed_d = elapsed_q;
		item_take = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		if (item_valid && !res_full) begin
			item_take = 1'b1;
			case (item.cmd)
				CMD_UPLOAD, CMD_DOWNLOAD: begin
					res_push = 1'b1;
					if (waiting) begin
						res.done_res = 1'b1;
						res.status   = ST_BUSY;
					end else if (!bus_on_q) begin
						res.done_res = 1'b1;
						res.status   = ST_BUS;
					end else if (item.cmd == CMD_DOWNLOAD && !item.size_ok) begin
						res.done_res = 1'b1;
						res.status   = ST_SIZE;
					end else begin
						res.tx_valid = 1'b1;
						res.tx_id    = item.tx_id;
						res.tx_data  = item.frame;
						phase_d      = (item.cmd == CMD_UPLOAD) ? PH_UPLOAD : PH_DOWNLOAD;
						exp_id_d     = item.exp_id;
						elapsed_d    = '0;
					end
				end
				CMD_FRAME, CMD_TICK: begin
					if (!waiting) begin
						phase_d = PH_IDLE;
					end else if (!bus_on_q) begin
						phase_d      = PH_IDLE;
						res_push     = 1'b1;
						res.done_res = 1'b1;
						res.status   = ST_BUS;
					end else if (item.cmd == CMD_FRAME) begin
						if (item.rx_hi_zero && item.rx_lo == exp_id_q) begin
							phase_d      = PH_IDLE;
							res_push     = 1'b1;
							res.done_res = 1'b1;
							if (phase_q == PH_DOWNLOAD) begin
								res.status = item.dl_ack ? ST_OK : ST_BADRESP;
							end else if (!item.up_class_ok) begin
								res.status = ST_BADRESP;
							end else if (!item.up_exp) begin
								res.status = ST_NOTEXP;
							end else begin
								res.status     = ST_OK;
								res.read_value = item.up_value;
								res.read_size  = item.up_size;
							end
						end
					end else begin
						elapsed_d = elapsed_inc;
						if (elapsed_inc >= timeout_q) begin
							phase_d      = PH_IDLE;
							res_push     = 1'b1;
							res.done_res = 1'b1;
							res.status   = ST_TIMEOUT;
						end
					end
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	sdoc_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(DEPTH)
	) u_results (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res),
		.full  (res_full),
		.pop   (res_pop),
		.dout  (res_head),
		.empty (res_empty)
	);

endmodule

@@ tb/canopen_sdo_expedited_client_tb.sv @@
// Self-checking bench for the expedited SDO client: directed words, then random transfers.
// A scoreboard class predicts every result; it needs only sdoc_pkg and the client RTL.
`timescale 1ns / 1ps

module canopen_sdo_expedited_client_tb;
	import sdoc_pkg::*;

	localparam int HALF_PERIOD    = 5;
	localparam int RESET_CYCLES   = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_WORDS   = 1900;
	localparam int RANDOM_PHASES  = 10;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 8;

	typedef struct {
		cmd_t        cmd;
		logic [6:0]  node;
		logic [15:0] index;
		logic [7:0]  subindex;
		logic [31:0] value;
		logic [3:0]  size;
		logic [28:0] rx_id;
		logic [63:0] rx_data;
	} sdo_word_t;

	class sdo_scoreboard;
		bit          bus_up;
		logic [23:0] tick_limit;
		phase_t      xfer_phase;
		logic [10:0] resp_id;
		logic [23:0] ticks_seen;
		result_t     want_q[$];
		int          errors;
		int          checked;
		int          frames_sent;
		int          status_seen[7];

		function new();
			bus_up      = 1'b0;
			tick_limit  = TIMEOUT_RST;
			xfer_phase  = PH_IDLE;
			resp_id     = '0;
			ticks_seen  = '0;
			errors      = 0;
			checked     = 0;
			frames_sent = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [23:0] data);
			if (idx == REG_BUS_ON) begin
				bus_up = data[0];
			end else begin
				tick_limit = data;
			end
		endfunction

		function int pending();
			return want_q.size();
		endfunction

		function bit queue_done(status_t st, logic [31:0] val, logic [2:0] nbytes);
			result_t r;
			r            = '0;
			r.done_res   = 1'b1;
			r.status     = st;
			r.read_value = val;
			r.read_size  = nbytes;
			want_q.push_back(r);
			return 1'b1;
		endfunction

		// returns 1 when the word yields a result
		function bit note_word(sdo_word_t w);
			result_t     r;
			logic [63:0] frame;
			logic [63:0] mask;
			logic [7:0]  c0;
			logic [2:0]  nbytes;
			logic [1:0]  unused;
			bit          waiting;
			waiting = (xfer_phase == PH_UPLOAD || xfer_phase == PH_DOWNLOAD);
			if (w.cmd == CMD_UPLOAD || w.cmd == CMD_DOWNLOAD) begin
				if (waiting) return queue_done(ST_BUSY, '0, '0);
				if (!bus_up) return queue_done(ST_BUS, '0, '0);
				frame = {32'h0, w.subindex, w.index, 8'h00};
				if (w.cmd == CMD_UPLOAD) begin
					frame[7:0] = CCS_UPLOAD;
					xfer_phase = PH_UPLOAD;
				end else begin
					if (w.size == 0 || w.size > 4) return queue_done(ST_SIZE, '0, '0);
					unused       = 2'(4 - w.size);
					mask         = (64'd1 << (8 * w.size)) - 64'd1;
					frame[7:0]   = DL_CMD | {4'h0, unused, 2'b00};
					frame[63:32] = w.value & mask[31:0];
					xfer_phase   = PH_DOWNLOAD;
				end
				resp_id    = RX_BASE + 11'(w.node);
				ticks_seen = '0;
				r          = '0;
				r.tx_valid = 1'b1;
				r.tx_id    = TX_BASE + 11'(w.node);
				r.tx_data  = frame;
				want_q.push_back(r);
				return 1'b1;
			end
			if (!waiting) begin
				xfer_phase = PH_IDLE;
				return 1'b0;
			end
			if (!bus_up) begin
				xfer_phase = PH_IDLE;
				return queue_done(ST_BUS, '0, '0);
			end
			if (w.cmd == CMD_FRAME) begin
				c0 = w.rx_data[7:0];
				if (w.rx_id != {18'h0, resp_id}) return 1'b0;
				if (xfer_phase == PH_DOWNLOAD) begin
					xfer_phase = PH_IDLE;
					return queue_done(c0 == DL_ACK ? ST_OK : ST_BADRESP, '0, '0);
				end
				xfer_phase = PH_IDLE;
				if ((c0 & CLASS_MASK) != CCS_UPLOAD) return queue_done(ST_BADRESP, '0, '0);
				if ((c0 & EXP_BIT) == 8'h00) return queue_done(ST_NOTEXP, '0, '0);
				nbytes = ((c0 & SIZE_BIT) != 8'h00) ? 3'(4 - c0[3:2]) : 3'd4;
				mask   = (64'd1 << (8 * nbytes)) - 64'd1;
				return queue_done(ST_OK, w.rx_data[63:32] & mask[31:0], nbytes);
			end
			if (ticks_seen != TICKS_MAX) ticks_seen = ticks_seen + 24'd1;
			if (ticks_seen >= tick_limit) begin
				xfer_phase = PH_IDLE;
				return queue_done(ST_TIMEOUT, '0, '0);
			end
			return 1'b0;
		endfunction

		task report_error(string msg);
			errors++;
			$display("MISMATCH %0d at %0t: %s", errors, $realtime, msg);
		endtask

		task compare_field(string name, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report_error($sformatf("result %0d %s: got %h, want %h", checked, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			checked++;
			if (want_q.size() == 0) begin
				report_error($sformatf("result %0d arrived with nothing expected", checked));
				return;
			end
			want = want_q.pop_front();
			compare_field("tx_valid", 64'(got.tx_valid), 64'(want.tx_valid));
			compare_field("tx_id", 64'(got.tx_id), 64'(want.tx_id));
			compare_field("tx_data", got.tx_data, want.tx_data);
			compare_field("done_res", 64'(got.done_res), 64'(want.done_res));
			compare_field("status", 64'(got.status), 64'(want.status));
			compare_field("read_value", 64'(got.read_value), 64'(want.read_value));
			compare_field("read_size", 64'(got.read_size), 64'(want.read_size));
			if (want.done_res) begin
				status_seen[int'(want.status)]++;
			end else begin
				frames_sent++;
			end
		endtask
	endclass

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        push            = 1'b0;
	logic        full;
	logic [1:0]  command         = '0;
	logic [6:0]  server_node     = '0;
	logic [15:0] object_index    = '0;
	logic [7:0]  object_subindex = '0;
	logic [31:0] write_value     = '0;
	logic [3:0]  write_size      = '0;
	logic [28:0] rx_id           = '0;
	logic [63:0] rx_data         = '0;
	logic        empty;
	logic        pop             = 1'b0;
	logic        tx_valid;
	logic [10:0] tx_id;
	logic [63:0] tx_data;
	logic        done_res;
	logic [2:0]  status;
	logic [31:0] read_value;
	logic [2:0]  read_size;
	logic        wr_en           = 1'b0;
	logic        wr_index        = 1'b0;
	logic [23:0] wr_data         = '0;

	sdo_scoreboard sb = new();

	bit      gaps_on      = 1'b1;
	bit      rx_hold      = 1'b0;
	int      quiet_cycles = 0;
	int      words_in     = 0;
	int      result_words = 0;
	result_t popped;

	canopen_sdo_expedited_client dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.command         (command),
		.server_node     (server_node),
		.object_index    (object_index),
		.object_subindex (object_subindex),
		.write_value     (write_value),
		.write_size      (write_size),
		.rx_id           (rx_id),
		.rx_data         (rx_data),
		.empty           (empty),
		.pop             (pop),
		.tx_valid        (tx_valid),
		.tx_id           (tx_id),
		.tx_data         (tx_data),
		.done_res        (done_res),
		.status          (status),
		.read_value      (read_value),
		.read_size       (read_size),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold = 1'b0;
			end else if (gaps_on && $urandom_range(0, 9) == 0) begin
				pop = 1'b0;
				repeat ($urandom_range(0, 11)) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				popped.tx_valid   = tx_valid;
				popped.tx_id      = tx_id;
				popped.tx_data    = tx_data;
				popped.done_res   = done_res;
				popped.status     = status_t'(status);
				popped.read_value = read_value;
				popped.read_size  = read_size;
				sb.check_result(popped);
			end
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		wait (quiet_cycles >= WATCHDOG_LIMIT);
		$display("watchdog: no word moved for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, sb.pending());
		$display("canopen_sdo_expedited_client_tb: done, errors");
		$finish;
	end

	function automatic sdo_word_t mk(cmd_t c, logic [6:0] node, logic [15:0] idx,
			logic [7:0] sub, logic [31:0] val, logic [3:0] nbytes, logic [28:0] id,
			logic [63:0] data);
		sdo_word_t w;
		w.cmd      = c;
		w.node     = node;
		w.index    = idx;
		w.subindex = sub;
		w.value    = val;
		w.size     = nbytes;
		w.rx_id    = id;
		w.rx_data  = data;
		return w;
	endfunction

	function automatic sdo_word_t random_word();
		return mk(cmd_t'($urandom_range(0, 3)), 7'($urandom), 16'($urandom), 8'($urandom),
			$urandom, 4'($urandom), 29'($urandom), {$urandom, $urandom});
	endfunction

	task automatic send(sdo_word_t w);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		command         = w.cmd;
		server_node     = w.node;
		object_index    = w.index;
		object_subindex = w.subindex;
		write_value     = w.value;
		write_size      = w.size;
		rx_id           = w.rx_id;
		rx_data         = w.rx_data;
		push            = 1'b1;
		do @(posedge clk); while (full);
		words_in++;
		if (sb.note_word(w)) result_words++;
	endtask

	task automatic drain();
		@(negedge clk);
		push = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [23:0] data);
		@(negedge clk);
		wr_en    = 1'b1;
		wr_index = idx;
		wr_data  = data;
		@(negedge clk);
		wr_en = 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic random_transfer();
		sdo_word_t  w;
		logic [6:0] node;
		node   = 7'($urandom_range(0, 127));
		w      = random_word();
		w.node = node;
		w.cmd  = $urandom_range(0, 1) ? CMD_UPLOAD : CMD_DOWNLOAD;
		if ($urandom_range(0, 9) != 0) w.size = 4'($urandom_range(1, 4));
		send(w);
		repeat ($urandom_range(0, 3)) begin
			w = random_word();
			case ($urandom_range(0, 3))
				0: w.cmd = CMD_TICK;
				1: begin
					w.cmd   = CMD_FRAME;
					w.rx_id = 29'(RX_BASE + 11'($urandom_range(0, 127)));
				end
				2: w.cmd = CMD_FRAME;
				default: ;
			endcase
			send(w);
		end
		if ($urandom_range(0, 4) != 0) begin
			w       = random_word();
			w.cmd   = CMD_FRAME;
			w.rx_id = 29'(RX_BASE + 11'(node));
			case ($urandom_range(0, 3))
				0: w.rx_data[7:0] = DL_ACK;
				1, 2: w.rx_data[7:0] = {3'b010, 1'($urandom), 2'($urandom), 1'b1, 1'($urandom)};
				default: ;
			endcase
			send(w);
		end else begin
			repeat ($urandom_range(1, 6)) send(mk(CMD_TICK, 7'($urandom), 16'($urandom),
				8'($urandom), $urandom, 4'($urandom), 29'($urandom), {$urandom, $urandom}));
		end
	endtask

	initial begin
		int          target;
		bit          bus;
		logic [23:0] limit;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: bus down, default timeout
		send(mk(CMD_UPLOAD, 7'd0, 16'h0000, 8'h00, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_DOWNLOAD, 7'd127, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 4'd4, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h580, 64'h60));
		send(mk(CMD_TICK, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h0, 64'h0));
		drain();
		write_reg(REG_BUS_ON, 24'd1);
		write_reg(REG_TIMEOUT, 24'd0);
		send(mk(CMD_UPLOAD, 7'd127, 16'hFFFF, 8'hFF, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_TICK, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_DOWNLOAD, 7'd3, 16'h1234, 8'h01, 32'h12345678, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_DOWNLOAD, 7'd3, 16'h1234, 8'h01, 32'h12345678, 4'd15, 29'h0, 64'h0));
		send(mk(CMD_DOWNLOAD, 7'd127, 16'hFFFF, 8'hFF, 32'hFFFFFFFF, 4'd4, 29'h0, 64'h0));
		send(mk(CMD_UPLOAD, 7'd9, 16'h2000, 8'h00, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h1FFFFDFF, 64'h60));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h5FF, 64'hFFFFFFFF_FFFFFF60));
		send(mk(CMD_DOWNLOAD, 7'd0, 16'h6040, 8'h00, 32'hA5A5A5A5, 4'd1, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h580, 64'h61));
		send(mk(CMD_UPLOAD, 7'd1, 16'h1018, 8'h01, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h581, 64'h89ABCDEF_00000043));
		send(mk(CMD_UPLOAD, 7'd1, 16'h1018, 8'h02, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h581, 64'hFFFFFFFF_0000004F));
		send(mk(CMD_UPLOAD, 7'd1, 16'h1018, 8'h03, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h581, 64'h13579BDF_00000042));
		send(mk(CMD_UPLOAD, 7'd1, 16'h1018, 8'h04, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h581, 64'h11223344_00000041));
		send(mk(CMD_UPLOAD, 7'd1, 16'h1018, 8'h05, 32'h0, 4'd0, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h581, 64'h11223344_00000060));
		// leave an upload pending, then take the bus down under it
		send(mk(CMD_UPLOAD, 7'd64, 16'h5555, 8'hAA, 32'h0, 4'd0, 29'h0, 64'h0));
		drain();
		write_reg(REG_BUS_ON, 24'd0);
		send(mk(CMD_DOWNLOAD, 7'd64, 16'hAAAA, 8'h55, 32'h55555555, 4'd2, 29'h0, 64'h0));
		send(mk(CMD_FRAME, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h5C0, 64'h43));
		send(mk(CMD_TICK, 7'd0, 16'h0, 8'h0, 32'h0, 4'd0, 29'h0, 64'h0));

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain();
			case (p)
				0: begin bus = 1'b1; limit = 24'hFFFFFF; end
				1: begin bus = 1'b1; limit = 24'd0; end
				2: begin bus = 1'b1; limit = 24'd1; end
				3: begin bus = 1'b0; limit = 24'd3; end
				default: begin
					bus   = ($urandom_range(0, 5) != 0);
					limit = 24'($urandom_range(2, 12));
				end
			endcase
			write_reg(REG_BUS_ON, 24'(bus));
			write_reg(REG_TIMEOUT, limit);
			gaps_on = !(p == 2 || p >= RANDOM_PHASES - 2);
			if (p == 4) begin
				@(posedge clk);
				rx_hold = 1'b1;
				repeat (20) send(mk(cmd_t'($urandom_range(0, 1)), 7'($urandom), 16'($urandom),
					8'($urandom), $urandom, 4'($urandom_range(1, 4)), 29'($urandom),
					{$urandom, $urandom}));
			end
			target = words_in + RANDOM_WORDS / RANDOM_PHASES;
			while (words_in < target) random_transfer();
		end

		drain();
		if (sb.pending() != 0) sb.report_error("expected results left over");
		$display("covered %0d words in, %0d results expected, %0d checked, %0d request frames",
			words_in, result_words, sb.checked, sb.frames_sent);
		$display("status ok %0d, bus %0d, size %0d, bad resp %0d, not exp %0d, timeout %0d, busy %0d",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
			sb.status_seen[4], sb.status_seen[5], sb.status_seen[6]);
		if (sb.errors == 0) begin
			$display("canopen_sdo_expedited_client_tb: done, clean");
		end else begin
			$display("canopen_sdo_expedited_client_tb: done, errors");
		end
		$finish;
	end

endmodule
